// ===== sv/mrfrb_pkg.sv =====
package mrfrb_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int FRAME_WIDTH_DEF = 32;
    localparam int READERS_DEF     = 4;
    localparam int MAX_BURST_DEF   = 16;

    localparam int CMD_W    = 3;
    localparam int SEL_W    = 2;
    localparam int COUNT_W  = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 11;
    localparam int RDCFG_W  = 3;
    localparam int POS_W    = 32;
    localparam int IN_W     = CMD_W + SEL_W + COUNT_W + DATA_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = STATUS_W + 1 + DATA_W + COUNT_W + 2 * LEVEL_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_CHK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FAIL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_RED   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DROP      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEWEST    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOOFEW  = 2'd3;

    // register indexes
    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_READERS  = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SEL_W-1:0]   reader_sel;
        logic [COUNT_W-1:0] frame_count;
        logic [DATA_W-1:0]  push_frame;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  reader_available;
        logic [LEVEL_W-1:0]  writer_space;
        logic [COUNT_W-1:0]  frames_done;
        logic                last;
        logic [DATA_W-1:0]   pop_frame;
        logic                has_frame;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

// ===== sv/multi_reader_frame_ring_buffer.sv =====
// Multi-reader frame ring buffer.
// s_axis carries one command beat (command, reader head, frame count, push
// frame); m_axis returns result beats: one per non-pop command, one per
// frame for a pop that moves frames, tlast on the final beat of a command.
// cfg_we/cfg_index/cfg_data write capacity (index 0) and the active reader
// count (index 1); write them only while the block is idle.
// A two-entry command queue sits ahead of the engine, so commands are taken
// while the engine works or a result waits.
// A push, query, newest or failed pop passes evaluate, a settle state and
// output before its beat; a pop repeats, for each frame: previous beat
// leaves, store read, register, settle of the registered slowest-reader
// distance, emit; a drop advances its head one slot per step before its
// single beat. The engine handles one command at a time and takes the
// next only once its last beat has left.
// Reset clears all heads and positions, capacity to 1024, one active reader.
// Store contents are undefined until written. When m_axis_tready is low the
// engine holds its result register and stops; the queue then fills and
// s_axis_tready drops.
module multi_reader_frame_ring_buffer
    import mrfrb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEF,
    parameter int READERS     = READERS_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command, reader_sel, frame_count, push_frame
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status, has_frame, pop_frame, frames_done, writer_space, reader_available
    output logic [OUT_BYTES_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t r;

    assign in_cmd.command     = s_axis_tdata[2:0];
    assign in_cmd.reader_sel  = s_axis_tdata[4:3];
    assign in_cmd.frame_count = s_axis_tdata[9:5];
    assign in_cmd.push_frame  = s_axis_tdata[41:10];

    mrfrb_cmd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    mrfrb_engine #(
        .DEPTH(DEPTH), .FRAME_WIDTH(FRAME_WIDTH),
        .READERS(READERS), .MAX_BURST(MAX_BURST)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tlast = r.last;
    assign m_axis_tdata = {{(OUT_BYTES_W-OUT_W){1'b0}}, r.reader_available,
                           r.writer_space, r.frames_done, r.pop_frame,
                           r.has_frame, r.status};

`ifndef SYNTH
    a_nohas_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !r.has_frame |-> r.last) else $error("non-pop without last");
    a_nohas_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !r.has_frame |-> r.pop_frame == '0) else $error("stray frame");
    a_avail_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> r.reader_available <= LEVEL_W'(DEPTH)) else $error("avail range");
`endif
endmodule

// ===== sv/mrfrb_cmd_queue.sv =====
module mrfrb_cmd_queue
    import mrfrb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    // two-entry queue between the input side and the engine
    cmd_t       mem_reg [2];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/mrfrb_engine.sv =====
module mrfrb_engine
    import mrfrb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEF,
    parameter int READERS     = READERS_DEF,
    parameter int MAX_BURST   = MAX_BURST_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [LEVEL_W-1:0] cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW = $clog2(DEPTH + 1) > LEVEL_W ? $clog2(DEPTH + 1) : LEVEL_W;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_POP, S_POPW, S_WAIT, S_OUT} state_t;

    state_t state_reg;
    logic [FRAME_WIDTH-1:0] store [DEPTH];
    logic [FRAME_WIDTH-1:0] rd_data_reg;
    logic [POS_W-1:0] wpos_reg;
    logic [POS_W-1:0] rpos_reg [READERS];
    logic [AW-1:0]    wslot_reg;
    logic [AW-1:0]    rslot_reg [READERS];
    logic [LEVEL_W-1:0] cap_cfg_reg;
    logic [RDCFG_W-1:0] rdr_cfg_reg;
    cmd_t             cur_reg;
    logic [HW-1:0]    h_reg;
    logic [COUNT_W-1:0] n_reg, i_reg;
    logic [POS_W-1:0] worst_reg;
    res_t             res_reg;
    logic             res_valid_reg;

    // effective configuration
    logic [CW-1:0] cap;
    logic [4:0]    nrd;
    always_comb begin
        if (cap_cfg_reg == '0) cap = CW'(1);
        else if ({{(32-LEVEL_W){1'b0}}, cap_cfg_reg} > 32'(DEPTH)) cap = CW'(DEPTH);
        else cap = CW'(cap_cfg_reg);
        if (rdr_cfg_reg == '0) nrd = 5'd1;
        else if (32'(rdr_cfg_reg) > 32'(READERS)) nrd = 5'(READERS);
        else nrd = 5'(rdr_cfg_reg);
    end

    // slowest active reader distance, registered max over heads
    logic [POS_W-1:0] worst_now;
    always_comb begin
        worst_now = '0;
        for (int k = 0; k < READERS; k++) begin
            if (5'(k) < nrd && (wpos_reg - rpos_reg[k]) > worst_now)
                worst_now = wpos_reg - rpos_reg[k];
        end
    end

    logic [POS_W-1:0] dist_h;
    logic [POS_W-1:0] cap32;
    logic [LEVEL_W-1:0] space_v, avail_v;
    assign dist_h  = wpos_reg - rpos_reg[h_reg];
    assign cap32   = 32'(cap);
    assign space_v = (worst_reg >= cap32) ? '0 : LEVEL_W'(cap32 - worst_reg);
    assign avail_v = (dist_h > cap32) ? LEVEL_W'(cap) : LEVEL_W'(dist_h);

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] s, input logic [CW-1:0] c);
        logic [CW:0] n;
        n = {{(CW+1-AW){1'b0}}, s} + 1'b1;
        return (n >= {1'b0, c}) ? '0 : AW'(n);
    endfunction

    // fold the reader select into the heads present; it never exceeds 3
    function automatic logic [HW-1:0] head_of(input logic [SEL_W-1:0] s);
        if (READERS == 1) return '0;
        else if (32'(s) >= 32'(READERS)) return HW'(32'(s) - 32'(READERS));
        else return HW'(s);
    endfunction

    logic [COUNT_W-1:0] fc;
    assign fc = (32'(cur_reg.frame_count) > 32'(MAX_BURST)) ? COUNT_W'(MAX_BURST)
                                                           : cur_reg.frame_count;

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // store port
    always_ff @(posedge aclk) begin
        if (state_reg == S_EVAL && (cur_reg.command == CMD_PUSH_FRC ||
            (cur_reg.command == CMD_PUSH_CHK && space_v != '0)))
            store[wslot_reg] <= cur_reg.push_frame[FRAME_WIDTH-1:0];
        rd_data_reg <= store[rslot_reg[h_reg]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            wpos_reg      <= '0;
            wslot_reg     <= '0;
            worst_reg     <= '0;
            cap_cfg_reg   <= LEVEL_W'(1024);
            rdr_cfg_reg   <= RDCFG_W'(1);
            for (int k = 0; k < READERS; k++) begin
                rpos_reg[k]  <= '0;
                rslot_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_CAPACITY) cap_cfg_reg <= cfg_data;
                else rdr_cfg_reg <= cfg_data[RDCFG_W-1:0];
            end
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            worst_reg <= worst_now;
            unique case (state_reg)
                S_IDLE: begin
                    // take a command only once the previous beat has left
                    if (cmd_valid && !res_valid_reg) begin
                        cur_reg   <= cmd;
                        h_reg     <= head_of(cmd.reader_sel);
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    res_reg.has_frame   <= 1'b0;
                    res_reg.pop_frame   <= '0;
                    res_reg.last        <= 1'b1;
                    res_reg.frames_done <= '0;
                    res_reg.status      <= ST_OK;
                    state_reg           <= S_WAIT;
                    priority case (cur_reg.command)
                        CMD_PUSH_CHK, CMD_PUSH_FRC: begin
                            if (cur_reg.command == CMD_PUSH_CHK && space_v == '0) begin
                                res_reg.status <= ST_NOSPACE;
                            end else begin
                                wpos_reg  <= wpos_reg + 1'b1;
                                wslot_reg <= nxt(wslot_reg, cap);
                            end
                        end
                        CMD_POP_FAIL, CMD_POP_RED: begin
                            if (dist_h > cap32) begin
                                res_reg.status <= ST_OVERRUN;
                            end else if (dist_h < 32'(fc) && cur_reg.command == CMD_POP_FAIL) begin
                                res_reg.status <= ST_TOOFEW;
                            end else if (dist_h < 32'(fc)) begin
                                n_reg <= COUNT_W'(dist_h);
                                if (dist_h != '0) state_reg <= S_POP;
                            end else begin
                                n_reg <= fc;
                                if (fc != '0) state_reg <= S_POP;
                            end
                            i_reg <= '0;
                        end
                        CMD_DROP: begin
                            // advance up to the request, one slot a cycle
                            n_reg <= (dist_h < 32'(fc)) ? COUNT_W'(dist_h) : fc;
                            res_reg.frames_done <= (dist_h < 32'(fc)) ? COUNT_W'(dist_h) : fc;
                            i_reg <= '0;
                            state_reg <= S_POP;
                        end
                        CMD_NEWEST: begin
                            rpos_reg[h_reg]  <= wpos_reg;
                            rslot_reg[h_reg] <= wslot_reg;
                        end
                        default: ;
                    endcase
                end
                S_POP: begin
                    // read slot data is valid next cycle; a drop advances its head here
                    if (i_reg == n_reg) begin
                        state_reg <= S_OUT;
                    end else if (cur_reg.command == CMD_DROP) begin
                        rpos_reg[h_reg]  <= rpos_reg[h_reg] + 1'b1;
                        rslot_reg[h_reg] <= nxt(rslot_reg[h_reg], cap);
                        i_reg <= i_reg + 1'b1;
                    end else if (!res_valid_reg) begin
                        state_reg <= S_POPW;
                    end
                end
                S_POPW: begin
                    rpos_reg[h_reg]  <= rpos_reg[h_reg] + 1'b1;
                    rslot_reg[h_reg] <= nxt(rslot_reg[h_reg], cap);
                    res_reg.has_frame   <= 1'b1;
                    res_reg.pop_frame   <= DATA_W'(rd_data_reg);
                    res_reg.frames_done <= n_reg;
                    res_reg.status      <= ST_OK;
                    res_reg.last        <= (i_reg + 1'b1 == n_reg);
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    // let the registered slowest-reader distance catch up
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // publish levels and raise valid once the output is free
                    if (!res_valid_reg || res_ready) begin
                        res_reg.writer_space     <= space_v;
                        res_reg.reader_available <= avail_v;
                        res_valid_reg <= 1'b1;
                        if (res_reg.last) state_reg <= S_IDLE;
                        else state_reg <= S_POP;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import mrfrb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

    // one expected result beat
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                has_frame;
        logic [DATA_W-1:0]   pop_frame;
        logic                last;
        logic [COUNT_W-1:0]  frames_done;
        logic [LEVEL_W-1:0]  writer_space;
        logic [LEVEL_W-1:0]  reader_available;
    } beat_t;

    // directed row: either a command or a register write
    typedef struct {
        bit                  is_reg;
        logic [0:0]          reg_idx;
        logic [LEVEL_W-1:0]  reg_val;
        logic [CMD_W-1:0]    command;
        logic [SEL_W-1:0]    sel;
        logic [COUNT_W-1:0]  count;
        logic [DATA_W-1:0]   frame;
        bit                  typed;
        logic [STATUS_W-1:0] t_status;
        logic [LEVEL_W-1:0]  t_space;
        logic [LEVEL_W-1:0]  t_avail;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = '0;
    logic [LEVEL_W-1:0]     cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    multi_reader_frame_ring_buffer i_dut (.*);

    // ring state mirror
    logic [DATA_W-1:0]  ring_store [DEPTH_DEF];
    logic [31:0]        wr_pos;
    logic [31:0]        rd_pos [READERS_DEF];
    logic [9:0]         wr_slot;
    logic [9:0]         rd_slot [READERS_DEF];
    logic [LEVEL_W-1:0] cap_reg;
    logic [RDCFG_W-1:0] readers_reg;

    beat_t expected_beats[$];
    int    mismatches = 0;
    int    tx_idle = 0;
    int    rx_idle = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int unsigned eff_cap();
        if (cap_reg < 1) return 1;
        if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
        return 32'(cap_reg);
    endfunction

    function automatic int unsigned eff_readers();
        if (readers_reg < 1) return 1;
        if (readers_reg > READERS_DEF) return READERS_DEF;
        return 32'(readers_reg);
    endfunction

    function automatic logic [9:0] slot_after(logic [9:0] s);
        int unsigned n;
        n = s + 1;
        return (n >= eff_cap()) ? 10'd0 : n[9:0];
    endfunction

    function automatic logic [31:0] lag(int h);
        return wr_pos - rd_pos[h];
    endfunction

    function automatic logic [LEVEL_W-1:0] free_slots();
        logic [31:0] worst;
        worst = 0;
        for (int k = 0; k < eff_readers(); k++)
            if (lag(k) > worst) worst = lag(k);
        return (worst >= eff_cap()) ? '0 : LEVEL_W'(eff_cap() - worst);
    endfunction

    function automatic logic [LEVEL_W-1:0] frames_ready(int h);
        return (lag(h) > eff_cap()) ? LEVEL_W'(eff_cap()) : LEVEL_W'(lag(h));
    endfunction

    // queue one beat, levels taken after the state change
    function automatic void add_beat(logic [STATUS_W-1:0] st, logic has,
                                     logic [DATA_W-1:0] fr, logic lst,
                                     logic [COUNT_W-1:0] done, int h);
        beat_t b;
        b.status = st;
        b.has_frame = has;
        b.pop_frame = fr;
        b.last = lst;
        b.frames_done = done;
        b.writer_space = free_slots();
        b.reader_available = frames_ready(h);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // advance the mirror by one command and queue its result beats
    function automatic void ring_command(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                                         logic [COUNT_W-1:0] cnt,
                                         logic [DATA_W-1:0] fr);
        int h;
        logic [31:0] n;
        h = sel;
        n = (cnt > MAX_BURST_DEF) ? MAX_BURST_DEF : cnt;
        case (cmd)
            CMD_PUSH_CHK, CMD_PUSH_FRC: begin
                if (cmd == CMD_PUSH_CHK && free_slots() == 0) begin
                    add_beat(ST_NOSPACE, 0, '0, 1, '0, h);
                end else begin
                    ring_store[wr_slot] = fr;
                    wr_pos++;
                    wr_slot = slot_after(wr_slot);
                    add_beat(ST_OK, 0, '0, 1, '0, h);
                end
            end
            CMD_POP_FAIL, CMD_POP_RED: begin
                if (lag(h) > eff_cap()) begin
                    add_beat(ST_OVERRUN, 0, '0, 1, '0, h);
                end else if (lag(h) < n && cmd == CMD_POP_FAIL) begin
                    add_beat(ST_TOOFEW, 0, '0, 1, '0, h);
                end else begin
                    if (lag(h) < n) n = lag(h);
                    if (n == 0) add_beat(ST_OK, 0, '0, 1, '0, h);
                    for (int i = 0; i < n; i++) begin
                        fr = ring_store[rd_slot[h]];
                        rd_pos[h]++;
                        rd_slot[h] = slot_after(rd_slot[h]);
                        add_beat(ST_OK, 1, fr, i + 1 == n, n[COUNT_W-1:0], h);
                    end
                end
            end
            CMD_DROP: begin
                if (lag(h) < n) n = lag(h);
                for (int i = 0; i < n; i++) begin
                    rd_pos[h]++;
                    rd_slot[h] = slot_after(rd_slot[h]);
                end
                add_beat(ST_OK, 0, '0, 1, n[COUNT_W-1:0], h);
            end
            CMD_NEWEST: begin
                rd_pos[h] = wr_pos;
                rd_slot[h] = wr_slot;
                add_beat(ST_OK, 0, '0, 1, '0, h);
            end
            default: add_beat(ST_OK, 0, '0, 1, '0, h);
        endcase
    endfunction

    // drive one command beat; predict once it is taken
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [SEL_W-1:0] sel,
                            logic [COUNT_W-1:0] cnt, logic [DATA_W-1:0] fr);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, fr, cnt, sel, cmd};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ring_command(cmd, sel, cnt, fr);
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    // write a register while idle; align all heads before a capacity change
    task automatic write_reg(logic [0:0] idx, logic [LEVEL_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        if (idx == REG_CAPACITY) begin
            for (int h = 0; h < READERS_DEF; h++) send_cmd(CMD_NEWEST, SEL_W'(h), '0, '0);
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_CAPACITY) cap_reg = val;
        else readers_reg = val[RDCFG_W-1:0];
    endtask

    function automatic row_t cmd_row(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
                                     logic [COUNT_W-1:0] n, logic [DATA_W-1:0] f);
        row_t r;
        r = '{default: '0};
        r.command = c;
        r.sel = s;
        r.count = n;
        r.frame = f;
        return r;
    endfunction

    function automatic row_t typed_row(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s,
                                       logic [COUNT_W-1:0] n, logic [STATUS_W-1:0] st,
                                       logic [LEVEL_W-1:0] sp, logic [LEVEL_W-1:0] av);
        row_t r;
        r = cmd_row(c, s, n, '0);
        r.typed = 1;
        r.t_status = st;
        r.t_space = sp;
        r.t_avail = av;
        return r;
    endfunction

    function automatic row_t reg_row(logic [0:0] idx, logic [LEVEL_W-1:0] val);
        row_t r;
        r = '{default: '0};
        r.is_reg = 1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // one random command, weighted toward pushes and pops
    task automatic random_cmd();
        int pick;
        logic [CMD_W-1:0] c;
        logic [COUNT_W-1:0] n;
        pick = $urandom_range(99);
        if (pick < 40) c = ($urandom_range(3) == 0) ? CMD_PUSH_FRC : CMD_PUSH_CHK;
        else if (pick < 75) c = ($urandom_range(1) == 0) ? CMD_POP_FAIL : CMD_POP_RED;
        else if (pick < 85) c = CMD_DROP;
        else if (pick < 90) c = CMD_NEWEST;
        else if (pick < 98) c = CMD_QUERY;
        else c = CMD_SPARE;
        n = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(31))
                                     : COUNT_W'($urandom_range(6));
        send_cmd(c, SEL_W'($urandom_range(3)), n, $urandom);
    endtask

    // receive side: random stall and in-order beat compare
    always @(posedge aclk) begin
        beat_t e;
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                e = expected_beats.pop_front();
                if (m_axis_tdata[1:0] !== e.status ||
                    m_axis_tdata[2] !== e.has_frame ||
                    m_axis_tdata[34:3] !== e.pop_frame ||
                    m_axis_tlast !== e.last ||
                    m_axis_tdata[39:35] !== e.frames_done ||
                    m_axis_tdata[50:40] !== e.writer_space ||
                    m_axis_tdata[61:51] !== e.reader_available) begin
                    $display({"%0t: mismatch expected st %0d has %0d frame %h last %0d ",
                              "done %0d space %0d avail %0d; actual st %0d has %0d ",
                              "frame %h last %0d done %0d space %0d avail %0d"},
                             $time, e.status, e.has_frame, e.pop_frame, e.last,
                             e.frames_done, e.writer_space, e.reader_available,
                             m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[34:3],
                             m_axis_tlast, m_axis_tdata[39:35], m_axis_tdata[50:40],
                             m_axis_tdata[61:51]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        row_t plan[$];
        int   cnt;
        wr_pos = 0;
        wr_slot = 10'd0;
        for (int h = 0; h < READERS_DEF; h++) begin
            rd_pos[h] = 0;
            rd_slot[h] = '0;
        end
        foreach (ring_store[i]) ring_store[i] = '0;
        cap_reg = LEVEL_W'(1024);
        readers_reg = RDCFG_W'(1);

        // directed plan: reset state, bursts, clamps, then a one-slot ring
        plan.insert(plan.size(), typed_row(CMD_QUERY, 0, 0, ST_OK, 1024, 0));
        plan.insert(plan.size(), typed_row(CMD_POP_FAIL, 0, 1, ST_TOOFEW, 1024, 0));
        plan.insert(plan.size(), typed_row(CMD_POP_RED, 1, 0, ST_OK, 1024, 0));
        plan.insert(plan.size(), cmd_row(CMD_PUSH_CHK, 0, 0, 32'h0000_0000));
        plan.insert(plan.size(), cmd_row(CMD_PUSH_FRC, 3, 31, 32'hFFFF_FFFF));
        plan.insert(plan.size(), cmd_row(CMD_PUSH_CHK, 0, 0, 32'hA5A5_5A5A));
        plan.insert(plan.size(), typed_row(CMD_POP_FAIL, 0, 31, ST_TOOFEW, 1021, 3));
        plan.insert(plan.size(), cmd_row(CMD_POP_RED, 0, 31, '0));
        for (int i = 0; i < 4; i++)
            plan.insert(plan.size(), cmd_row(CMD_PUSH_CHK, 2, 0, 32'h1234_0000 + i));
        plan.insert(plan.size(), cmd_row(CMD_DROP, 0, 2, '0));
        plan.insert(plan.size(), cmd_row(CMD_POP_FAIL, 0, 2, '0));
        plan.insert(plan.size(), cmd_row(CMD_NEWEST, 1, 0, '0));
        plan.insert(plan.size(), cmd_row(CMD_QUERY, 3, 0, '0));
        plan.insert(plan.size(), cmd_row(CMD_SPARE, 2, 31, 32'hDEAD_BEEF));
        plan.insert(plan.size(), cmd_row(CMD_DROP, 2, 31, '0));
        plan.insert(plan.size(), reg_row(REG_CAPACITY, 1));
        plan.insert(plan.size(), reg_row(REG_READERS, 4));
        plan.insert(plan.size(), cmd_row(CMD_PUSH_CHK, 0, 0, 32'h5555_AAAA));
        plan.insert(plan.size(), typed_row(CMD_PUSH_CHK, 0, 0, ST_NOSPACE, 0, 1));
        plan.insert(plan.size(), cmd_row(CMD_PUSH_FRC, 0, 0, 32'h8000_0001));
        plan.insert(plan.size(), typed_row(CMD_POP_FAIL, 0, 1, ST_OVERRUN, 0, 1));
        plan.insert(plan.size(), cmd_row(CMD_POP_RED, 0, 1, '0));
        plan.insert(plan.size(), cmd_row(CMD_DROP, 1, 16, '0));
        plan.insert(plan.size(), cmd_row(CMD_POP_RED, 1, 1, '0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed plan
        tx_idle = 13;
        rx_idle = 65;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_cmd(plan[i].command, plan[i].sel, plan[i].count, plan[i].frame);
                // for a typed row, the single beat of this command is the newest one queued
                cnt = expected_beats.size() - 1;
                if (plan[i].typed) begin
                    expected_beats[cnt].status = plan[i].t_status;
                    expected_beats[cnt].writer_space = plan[i].t_space;
                    expected_beats[cnt].reader_available = plan[i].t_avail;
                end
            end
        end

        // random phases: receiver-heavy idle, sender-heavy idle, none
        write_reg(REG_CAPACITY, 8);
        write_reg(REG_READERS, 2);
        for (int i = 0; i < 92; i++) random_cmd();

        write_reg(REG_CAPACITY, 2047);
        write_reg(REG_READERS, 7);
        tx_idle = 65;
        rx_idle = 13;
        for (int i = 0; i < 92; i++) begin
            random_cmd();
            // hold off until everything outstanding has come back
            if (i == 50) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end

        write_reg(REG_CAPACITY, 0);
        write_reg(REG_READERS, 0);
        write_reg(REG_CAPACITY, 3);
        tx_idle = 0;
        rx_idle = 0;
        for (int i = 0; i < 92; i++) random_cmd();
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/mrfrb_pkg.sv
sv/mrfrb_cmd_queue.sv
sv/mrfrb_engine.sv
sv/multi_reader_frame_ring_buffer.sv
bench/tb_top.sv
